### rtl/core/djdc_pkg.sv
// Package for the date / Julian day number converter.
// Shared types, calendar constants, month table and the divide-by-25 helper.
// No dependencies.
`timescale 1ns / 1ps

package djdc_pkg;

	typedef logic signed [14:0] year_t;
	typedef logic signed [23:0] sjdn_t;

	// Day number of 1 Jan 1 and 31 Dec 9999
	localparam logic [22:0] JDN_FIRST = 23'd1721424;
	localparam logic [22:0] JDN_LAST = 23'd5373484;
	// Gregorian year start offset and Julian epoch offsets
	localparam sjdn_t GREG_BASE = 24'sd1721061;
	localparam sjdn_t JUL_OFS = 24'sd4713;
	localparam sjdn_t JUL_LEAP_OFS = 24'sd4715;
	localparam sjdn_t DAYS_LEAP = 24'sd366;
	localparam logic [13:0] REFORM_YEAR = 14'd1752;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [8:0] GAP_DOY = 9'd246;
	localparam logic [8:0] GAP_DAYS = 9'd11;
	// floor(n / 1461) reciprocal, 2^31 scale
	localparam logic [20:0] RECIP_1461 = 21'd1469872;
	localparam logic [11:0] DAYS_4Y = 12'd1461;

	// floor(v / 25) for v < 4096
	function automatic logic [7:0] div25(input logic [11:0] v);
		logic [24:0] p;
		p = {13'd0, v} * 25'd5243;
		return p[24:17];
	endfunction

	// Days before month idx+1; leap adds a day from March on
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
		logic [8:0] b;
		case (idx)
			4'd0: b = 9'd0;
			4'd1: b = 9'd31;
			4'd2: b = 9'd59;
			4'd3: b = 9'd90;
			4'd4: b = 9'd120;
			4'd5: b = 9'd151;
			4'd6: b = 9'd181;
			4'd7: b = 9'd212;
			4'd8: b = 9'd243;
			4'd9: b = 9'd273;
			4'd10: b = 9'd304;
			4'd11: b = 9'd334;
			default: b = 9'd365;
		endcase
		if (leap && idx >= 4'd2)
			b = b + 9'd1;
		return b;
	endfunction

endpackage

### rtl/core/djdc_year_start.sv
// Two-stage year start unit: day number of 1 Jan of a year and its leap flag.
// Julian rules up to 1752, Gregorian after. Depends on djdc_pkg.
`timescale 1ns / 1ps

module djdc_year_start (
	input logic clk,
	input logic en,
	input djdc_pkg::year_t year,
	output djdc_pkg::sjdn_t start,
	output logic leap
);
	import djdc_pkg::*;

	sjdn_t y_ext;
	sjdn_t ym1_sh;
	sjdn_t yp_sh;
	logic [11:0] q4;
	logic [11:0] p;

	logic greg_s1, zero_s1;
	logic [1:0] low2_s1;
	logic [11:0] p_s1;
	logic [24:0] prod_a_s1, prod_b_s1;
	sjdn_t base_g_s1, base_j_s1;

	sjdn_t start_s2;
	logic leap_s2;

	logic [7:0] q100, d25;
	logic [11:0] rem;
	sjdn_t ys_g;
	logic leap_g;

	// Stage 1: linear terms and the two divide-by-25 products
	always_comb begin
		y_ext = {{9{year[14]}}, year};
		ym1_sh = (y_ext - 24'sd1) >>> 2;
		yp_sh = (y_ext + JUL_LEAP_OFS) >>> 2;
		q4 = ym1_sh[11:0];
		p = y_ext[13:2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			greg_s1 <= (year > 15'sd1752);
			zero_s1 <= (year == 15'sd0);
			low2_s1 <= year[1:0];
			p_s1 <= p;
			prod_a_s1 <= {13'd0, q4} * 25'd5243;
			prod_b_s1 <= {13'd0, p} * 25'd5243;
			base_g_s1 <= GREG_BASE + y_ext * 24'sd365 + {12'd0, q4};
			base_j_s1 <= 24'sd1 + (y_ext + JUL_OFS) * 24'sd365 + yp_sh
				- ((year > 15'sd0) ? DAYS_LEAP : 24'sd0);
		end
	end

	// Stage 2: century terms and leap rule
	always_comb begin
		q100 = prod_a_s1[24:17];
		ys_g = base_g_s1 - {16'd0, q100} + {18'd0, q100[7:2]};
		d25 = prod_b_s1[24:17];
		rem = p_s1 - 12'({4'd0, d25} * 12'd25);
		leap_g = (low2_s1 == 2'd0) && ((rem != 12'd0) || (d25[1:0] == 2'd0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_s2 <= zero_s1 ? 24'sd0 : (greg_s1 ? ys_g : base_j_s1);
			leap_s2 <= !zero_s1 && (greg_s1 ? leap_g : (low2_s1 == 2'd0));
		end
	end

	assign start = start_s2;
	assign leap = leap_s2;

endmodule

### rtl/core/date_julian_day_converter.sv
// Calendar date <-> Julian day number converter, eight-stage pipeline.
// Depends on djdc_pkg and djdc_year_start.
//
//  channel | handshake           | payload
//  input   | in_valid / in_stall | mode, year_in, month_in, day_in, day_number_in
//  output  | out_valid/out_stall | day_number_out, year_out, month_out, day_out,
//          |                     | range_error
//
// One transaction per cycle while the pipeline is not held; out_valid is the stage 8
// valid bit, and the result is taken at a clock edge where out_stall is low.
// The depth is set by the year start units (two stages each) behind the
// reciprocal year estimate in the day-number path.
// Reset clears the stage valid bits only.
// The whole pipeline holds while the output register is full and stalled;
// in_stall follows that condition.
`timescale 1ns / 1ps

module date_julian_day_converter (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input djdc_pkg::year_t year_in,
	input logic [3:0] month_in,
	input logic [4:0] day_in,
	input logic [22:0] day_number_in,
	output logic out_valid,
	input logic out_stall,
	output logic [22:0] day_number_out,
	output logic [13:0] year_out,
	output logic [3:0] month_out,
	output logic [4:0] day_out,
	output logic range_error
);
	import djdc_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7, mode_s8;

	// mode 0 path
	year_t y_s1, y_s2, y_s3;
	logic [3:0] m_s1, m_s2, m_s3;
	logic [4:0] d_s1, d_s2, d_s3;
	sjdn_t ys_a;
	logic leap_a;
	logic [22:0] jn_s4, jn_s5, jn_s6, jn_s7, jn_s8;
	logic err_s4, err_s5, err_s6, err_s7, err_s8;

	// mode 1 path
	logic [22:0] jd_s1, jd_s2, jd_s3, jd_s4, jd_s5;
	logic jerr_s1, jerr_s2, jerr_s3;
	logic [23:0] n_s1, n_s2;
	logic [13:0] q_s2;
	logic [13:0] jy_s3, jy_s4, jy_s5;
	sjdn_t ys_b, ys_c;
	logic leap_b, leap_c;
	logic [13:0] t_s6, t_s7, t_s8;
	logic [8:0] doy_s6, doy_s7;
	logic leap_s6, leap_s7;
	logic [3:0] mon_s8;
	logic [4:0] day_s8;

	logic [3:0] m_clamp;
	logic [23:0] x_in;
	logic [44:0] prod;
	logic [24:0] r_rem;
	logic [13:0] jy;
	sjdn_t j0;
	logic e0;
	logic take_next;
	sjdn_t ys_sel;
	sjdn_t doy_full;
	logic [8:0] doy_adj;
	logic [3:0] mm;
	logic [8:0] mb;

	// Global advance: hold everything while the output is full and stalled
	assign en = !v_s8 || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: month clamp, range check, 4x+3 offset
	always_comb begin
		m_clamp = month_in;
		if (month_in == 4'd0)
			m_clamp = 4'd1;
		else if (month_in inside {[4'd13:4'd15]})
			m_clamp = 4'd12;
		x_in = {1'b0, day_number_in} - {1'b0, JDN_FIRST};
		prod = {21'd0, n_s1} * {24'd0, RECIP_1461};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			y_s1 <= year_in;
			m_s1 <= m_clamp;
			d_s1 <= day_in;
			jd_s1 <= day_number_in;
			jerr_s1 <= (day_number_in < JDN_FIRST) || (day_number_in > JDN_LAST);
			n_s1 <= {x_in[21:0], 2'b11};
		end
	end

	// Stage 2: reciprocal product for floor(n / 1461)
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			y_s2 <= y_s1;
			m_s2 <= m_s1;
			d_s2 <= d_s1;
			jd_s2 <= jd_s1;
			jerr_s2 <= jerr_s1;
			n_s2 <= n_s1;
			q_s2 <= prod[44:31];
		end
	end

	// Stage 3: one-step quotient correction gives the Julian-rule year
	always_comb begin
		r_rem = {1'b0, n_s2} - 25'({11'd0, q_s2} * 25'd1461);
		jy = q_s2 + 14'd1 + ((r_rem >= {13'd0, DAYS_4Y}) ? 14'd1 : 14'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			y_s3 <= y_s2;
			m_s3 <= m_s2;
			d_s3 <= d_s2;
			jd_s3 <= jd_s2;
			jerr_s3 <= jerr_s2;
			jy_s3 <= jy;
		end
	end

	// Year start for the mode 0 input year
	djdc_year_start u_ys_a (
		.clk(clk),
		.en(en),
		.year(y_s1),
		.start(ys_a),
		.leap(leap_a)
	);

	// Stage 4: mode 0 day number; error merged for both modes
	always_comb begin
		j0 = ys_a + {15'd0, month_start(1'b0, m_s3 - 4'd1)} + {19'd0, d_s3} - 24'sd1;
		if ((y_s3 == 15'sd1752) && ((m_s3 >= 4'd10) || ((m_s3 == 4'd9) && (d_s3 >= 5'd14))))
			j0 = j0 - 24'sd11;
		if (leap_a && (m_s3 >= 4'd3))
			j0 = j0 + 24'sd1;
		e0 = (y_s3 == 15'sd0) || j0[23];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			jd_s4 <= jd_s3;
			jy_s4 <= jy_s3;
			err_s4 <= mode_s3 ? jerr_s3 : e0;
			jn_s4 <= (mode_s3 || e0) ? 23'd0 : j0[22:0];
		end
	end

	// Year starts for the candidate year and the one after it
	djdc_year_start u_ys_b (
		.clk(clk),
		.en(en),
		.year({1'b0, jy_s3}),
		.start(ys_b),
		.leap(leap_b)
	);

	djdc_year_start u_ys_c (
		.clk(clk),
		.en(en),
		.year({1'b0, jy_s3 + 14'd1}),
		.start(ys_c),
		.leap(leap_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= mode_s4;
			jd_s5 <= jd_s4;
			jy_s5 <= jy_s4;
			err_s5 <= err_s4;
			jn_s5 <= jn_s4;
		end
	end

	// Stage 6: pick the year, day of year
	always_comb begin
		take_next = (jy_s5 < YEAR_MAX) && (ys_c <= $signed({1'b0, jd_s5}));
		ys_sel = take_next ? ys_c : ys_b;
		doy_full = $signed({1'b0, jd_s5}) - ys_sel;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s6 <= mode_s5;
			err_s6 <= err_s5;
			jn_s6 <= jn_s5;
			t_s6 <= take_next ? (jy_s5 + 14'd1) : jy_s5;
			leap_s6 <= take_next ? leap_c : leap_b;
			doy_s6 <= doy_full[8:0];
		end
	end

	// Stage 7: skip the September 1752 gap
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s7 <= mode_s6;
			err_s7 <= err_s6;
			jn_s7 <= jn_s6;
			t_s7 <= t_s6;
			leap_s7 <= leap_s6;
			doy_s7 <= ((t_s6 == REFORM_YEAR) && (doy_s6 >= GAP_DOY)) ? doy_s6 + GAP_DAYS
				: doy_s6;
		end
	end

	// Stage 8: month search over the table, output register
	always_comb begin
		doy_adj = doy_s7;
		mm = 4'd1;
		mb = 9'd0;
		for (int i = 0; i < 12; i++) begin
			if (month_start(leap_s7, 4'(i)) <= doy_adj) begin
				mm = 4'(i + 1);
				mb = month_start(leap_s7, 4'(i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s8 <= mode_s7;
			err_s8 <= err_s7;
			jn_s8 <= jn_s7;
			t_s8 <= (mode_s7 && !err_s7) ? t_s7 : 14'd0;
			mon_s8 <= (mode_s7 && !err_s7) ? mm : 4'd0;
			day_s8 <= (mode_s7 && !err_s7) ? 5'(doy_adj - mb + 9'd1) : 5'd0;
		end
	end

	assign out_valid = v_s8;
	assign day_number_out = mode_s8 ? 23'd0 : jn_s8;
	assign year_out = t_s8;
	assign month_out = mon_s8;
	assign day_out = day_s8;
	assign range_error = err_s8;

endmodule

### dv/tb_date_julian_day_converter.sv
// Testbench for date_julian_day_converter: directed and random conversions in both modes.
// Depends on djdc_pkg and the converter RTL; a scoreboard class holds the expected results.
`timescale 1ns / 1ps

class date_scoreboard;
	typedef struct {
		logic [22:0] jdn;
		logic [13:0] yr;
		logic [3:0] mon;
		logic [4:0] dom;
		logic err;
	} conv_t;

	conv_t pending[$];
	int mismatches;

	static function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q -= 1;
		return q;
	endfunction

	static function automatic longint first_day(longint y);
		if (y > 1752)
			return 1721061 + 365 * y + fdiv(y - 1, 4) - fdiv(y - 1, 100) + fdiv(y - 1, 400);
		if (y > 0)
			return 1 + 365 * (y + 4713) + fdiv(y + 4715, 4) - 366;
		if (y < 0)
			return 1 + 365 * (y + 4713) + fdiv(y + 4715, 4);
		return 0;
	endfunction

	static function automatic bit leap(longint y);
		if (y > 1752)
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		if (y > 0)
			return (y % 4) == 0;
		if (y < 0)
			return ((-y) % 4) == 0;
		return 0;
	endfunction

	// days before each month, plus the leap day from March on in a leap year
	static function automatic longint days_before(bit lp, int idx);
		int cum[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
		return cum[idx] + ((lp && idx >= 2) ? 1 : 0);
	endfunction

	// expected conversion for one accepted transaction
	function void note_input(logic mode, logic signed [14:0] year_in, logic [3:0] month_in,
			logic [4:0] day_in, logic [22:0] day_number_in);
		conv_t r;
		longint y, m, d, j, yy, doy;
		int mm;
		bit lp;
		r = '{default: '0};
		y = year_in;
		m = month_in;
		d = day_in;
		j = day_number_in;
		if (mode == 1'b0) begin
			if (y == 0)
				r.err = 1;
			else begin
				if (m < 1)
					m = 1;
				if (m > 12)
					m = 12;
				j = first_day(y) + days_before(0, m - 1) + d - 1;
				if (y == 1752 && (m >= 10 || (m == 9 && d >= 14)))
					j -= 11;
				if (leap(y) && m >= 3)
					j += 1;
				if (j < 0)
					r.err = 1;
				else
					r.jdn = j[22:0];
			end
		end else if (j < 1721424 || j > 5373484)
			r.err = 1;
		else begin
			// direct search for the year containing this day
			yy = 1 + ((j - 1721424) * 4) / 1461;
			if (yy > 9999)
				yy = 9999;
			while (yy < 9999 && first_day(yy + 1) <= j)
				yy++;
			while (yy > 1 && first_day(yy) > j)
				yy--;
			doy = j - first_day(yy);
			if (yy == 1752 && doy >= 246)
				doy += 11;
			lp = leap(yy);
			mm = 1;
			while (mm < 12 && days_before(lp, mm) <= doy)
				mm++;
			doy -= days_before(lp, mm - 1);
			r.yr = yy[13:0];
			r.mon = mm[3:0];
			r.dom = doy[4:0] + 5'd1;
		end
		pending.push_back(r);
	endfunction

	// compare one result against the oldest expectation
	function void check_result(conv_t got);
		conv_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result jdn=%0d y=%0d", got.jdn, got.yr);
			return;
		end
		e = pending.pop_front();
		if (got != e) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: exp jdn=%0d y=%0d m=%0d d=%0d e=%0b",
					" got jdn=%0d y=%0d m=%0d d=%0d e=%0b"},
					e.jdn, e.yr, e.mon, e.dom, e.err,
					got.jdn, got.yr, got.mon, got.dom, got.err);
		end
	endfunction
endclass

module tb_date_julian_day_converter;
	import djdc_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic mode = 0;
	year_t year_in = '0;
	logic [3:0] month_in = '0;
	logic [4:0] day_in = '0;
	logic [22:0] day_number_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [22:0] day_number_out;
	logic [13:0] year_out;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic range_error;

	date_scoreboard board = new();
	bit stim_done = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	date_julian_day_converter uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// one transaction: present at falling edge, wait for acceptance
	task automatic send_item(logic md, logic signed [14:0] y, logic [3:0] m, logic [4:0] d,
			logic [22:0] j);
		mode <= md;
		year_in <= y;
		month_in <= m;
		day_in <= d;
		day_number_in <= j;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		board.note_input(md, y, m, d, j);
		@(negedge clk);
	endtask

	task automatic send_date(int y, int m, int d);
		send_item(0, y[14:0], m[3:0], d[4:0], 23'($urandom));
	endtask

	task automatic send_jdn(int j);
		send_item(1, 15'($urandom), 4'($urandom), 5'($urandom), j[22:0]);
	endtask

	task automatic send_random();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			send_date($urandom_range(0, 14712) - 4713, $urandom_range(0, 15),
				$urandom_range(0, 31));
		else if (sel == 4)
			send_item(0, 15'($urandom), 4'($urandom), 5'($urandom), 23'($urandom));
		else if (sel == 5)
			send_date(1752, $urandom_range(8, 10), $urandom_range(0, 31));
		else if (sel < 9)
			send_jdn($urandom_range(1721424, 5373484));
		else if (sel == 9 && $urandom_range(0, 1))
			send_jdn($urandom_range(2360000, 2361700));
		else
			send_item(1, 15'($urandom), 4'($urandom), 5'($urandom), 23'($urandom));
	endtask

	// sender: directed cases, then bursts with gaps
	initial begin
		int left, gap;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_date(0, 5, 5);
		send_date(-4713, 1, 1);
		send_date(-4714, 12, 31);
		send_date(-16384, 15, 31);
		send_date(16383, 15, 31);
		send_date(9999, 12, 31);
		send_date(-1, 2, 29);
		send_date(4, 0, 0);
		send_date(1752, 9, 2);
		send_date(1752, 9, 3);
		send_date(1752, 9, 14);
		send_date(1753, 3, 1);
		send_date(2000, 13, 31);
		send_jdn(0);
		send_jdn(1721423);
		send_jdn(1721424);
		send_jdn(5373484);
		send_jdn(5373485);
		send_jdn(8388607);
		send_jdn(2361221);
		send_jdn(2361222);
		send_jdn(2361231);
		// long receiver hold-off while items keep coming
		hold_off <= 1;
		repeat (40) send_random();
		left = 1700;
		while (left > 0) begin
			for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--, left--)
				send_random();
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int n;
		out_stall <= 0;
		wait (hold_off);
		@(negedge clk);
		out_stall <= 1;
		repeat (60) @(negedge clk);
		out_stall <= 0;
		forever begin
			n = $urandom_range(1, 40);
			repeat (n) @(negedge clk);
			case ($urandom_range(0, 2))
				0: out_stall <= 0;
				1: out_stall <= 1;
				default: out_stall <= $urandom_range(0, 1);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				repeat (n) begin
					@(negedge clk);
					out_stall <= $urandom_range(0, 1);
				end
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{day_number_out, year_out, month_out, day_out, range_error});
	end

	// watchdog and end of run
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
			if (stim_done && board.pending.size() == 0) begin
				repeat (20) @(posedge clk);
				if (board.mismatches == 0)
					$display("[ OK ] regression clean");
				else
					$display("[FAIL] regression broken");
				$finish;
			end
		end
	end
endmodule
